// File: sv/huaf_pkg.sv
// ----------------------------------------------------------------------------
// Heap use-after-free checker: shared package
// Sizes, opcodes, command encoding and the record layouts used by the front
// end, the back end and the channel interfaces.
// ----------------------------------------------------------------------------
package huaf_pkg;

  // Number of heap areas the table can track.
  localparam int unsigned AREA_ENTRIES = 64;
  localparam int unsigned IDX_W        = (AREA_ENTRIES > 1) ? $clog2(AREA_ENTRIES) : 1;
  localparam int unsigned CNT_W        = $clog2(AREA_ENTRIES + 1);

  // Fixed field widths of the request and response channels.
  localparam int unsigned WORD_W = 64;
  localparam int unsigned OPC_W  = 2;
  localparam int unsigned OPN_W  = 4;

  // Accesses are only checked when the instruction has this many operands.
  localparam logic [OPN_W-1:0] CHECKED_OPERANDS = 4'd2;

  // Request opcodes.
  typedef enum logic [OPC_W-1:0] {
    OP_ALLOC_SIZE = 2'd0,
    OP_ALLOC_RET  = 2'd1,
    OP_FREE       = 2'd2,
    OP_ACCESS     = 2'd3
  } opcode_e;

  // Commands handed from the front end to the back end.
  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_SET_SIZE,
    CMD_ALLOC,
    CMD_FREE,
    CMD_CHECK
  } cmd_e;

  // Classified request. The operand carries the allocation size for a size
  // record and the instruction address for an access check.
  typedef struct packed {
    cmd_e              cmd;
    logic [WORD_W-1:0] address;
    logic [WORD_W-1:0] operand;
    logic              is_write;
  } cmd_t;

  // One entry of the area table.
  typedef struct packed {
    logic              freed;
    logic [WORD_W-1:0] length;
    logic [WORD_W-1:0] base;
  } area_t;

  // One response.
  typedef struct packed {
    logic              uaf_detected;
    logic              fault_is_write;
    logic [WORD_W-1:0] fault_address;
    logic [WORD_W-1:0] fault_instruction;
    logic              area_table_full;
  } result_t;

endpackage

// File: sv/huaf_req_if.sv
// ----------------------------------------------------------------------------
// Heap use-after-free checker: request channel
// Valid/ready channel carrying one heap or memory event per request.
// ----------------------------------------------------------------------------
interface huaf_req_if;
  import huaf_pkg::*;

  logic              valid;
  logic              ready;
  logic [OPC_W-1:0]  opcode;
  logic [WORD_W-1:0] address;
  logic [WORD_W-1:0] alloc_size;
  logic              access_is_write;
  logic [OPN_W-1:0]  operand_count;
  logic [WORD_W-1:0] instr_address;

  modport source (
    output valid, opcode, address, alloc_size, access_is_write, operand_count,
           instr_address,
    input  ready
  );

  modport sink (
    input  valid, opcode, address, alloc_size, access_is_write, operand_count,
           instr_address,
    output ready
  );
endinterface

// File: sv/huaf_rsp_if.sv
// ----------------------------------------------------------------------------
// Heap use-after-free checker: response channel
// Valid/ready channel carrying one check result per request.
// ----------------------------------------------------------------------------
interface huaf_rsp_if;
  import huaf_pkg::*;

  logic              valid;
  logic              ready;
  logic              uaf_detected;
  logic              fault_is_write;
  logic [WORD_W-1:0] fault_address;
  logic [WORD_W-1:0] fault_instruction;
  logic              area_table_full;

  modport source (
    output valid, uaf_detected, fault_is_write, fault_address, fault_instruction,
           area_table_full,
    input  ready
  );

  modport sink (
    input  valid, uaf_detected, fault_is_write, fault_address, fault_instruction,
           area_table_full,
    output ready
  );
endinterface

// File: sv/huaf_front.sv
// ----------------------------------------------------------------------------
// Heap use-after-free checker: front end
// Accepts requests, classifies them into back-end commands and buffers them
// in a two-entry queue so that the request side does not wait on the scan.
// ----------------------------------------------------------------------------
module huaf_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  huaf_req_if.sink        req_i,
  output logic            cmd_valid_o,
  input  logic            cmd_ready_i,
  output huaf_pkg::cmd_t  cmd_o
);
  import huaf_pkg::*;

  cmd_t       queue_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  cmd_t       cmd_new;
  logic       push;
  logic       pop;

  // Classify the incoming request.
  always_comb begin
    cmd_new.address  = req_i.address;
    cmd_new.operand  = req_i.instr_address;
    cmd_new.is_write = req_i.access_is_write;
    cmd_new.cmd      = CMD_NOP;
    unique case (opcode_e'(req_i.opcode))
      OP_ALLOC_SIZE: begin
        cmd_new.cmd     = CMD_SET_SIZE;
        cmd_new.operand = req_i.alloc_size;
      end
      OP_ALLOC_RET: begin
        // A null return records nothing.
        cmd_new.cmd = (req_i.address == '0) ? CMD_NOP : CMD_ALLOC;
      end
      OP_FREE: begin
        cmd_new.cmd = CMD_FREE;
      end
      OP_ACCESS: begin
        cmd_new.cmd = (req_i.operand_count == CHECKED_OPERANDS) ? CMD_CHECK : CMD_NOP;
      end
      default: begin
        cmd_new.cmd = CMD_NOP;
      end
    endcase
  end

  // Queue handshakes.
  assign req_i.ready = (count_q != 2'd2);
  assign push        = req_i.valid && req_i.ready;
  assign cmd_valid_o = (count_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = queue_q[rd_ptr_q];

  // Queue pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// File: sv/huaf_back.sv
// ----------------------------------------------------------------------------
// Heap use-after-free checker: back end
// Holds the area table in a single-port memory and carries out one command
// at a time, scanning the filled entries: S_READ reads one, S_EVAL checks it.
// ----------------------------------------------------------------------------
module huaf_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  huaf_pkg::cmd_t  cmd_i,
  huaf_rsp_if.source      rsp_o
);
  import huaf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_FINISH
  } state_e;

  // Area table. Entries are filled from the bottom and never released, so
  // the fill count tells which entries are valid.
  area_t              area_mem [AREA_ENTRIES];
  area_t              rd_q;
  logic               mem_we;
  logic               mem_re;
  logic [IDX_W-1:0]   mem_waddr;
  area_t              mem_wdata;

  state_e             state_q;
  cmd_t               cmd_q;
  logic [CNT_W-1:0]   fill_q;
  logic [CNT_W-1:0]   scan_q;
  logic [WORD_W-1:0]  pending_q;
  logic               hit_q;
  logic               full_q;
  logic               rsp_valid_q;
  result_t            rsp_q;

  logic [IDX_W-1:0]   scan_idx;
  logic               scan_done;
  logic               table_full;
  logic               base_match;
  logic               in_area;
  logic               scan_stop;
  logic               cmd_take;
  logic               rsp_load;

  assign scan_idx   = scan_q[IDX_W-1:0];
  assign scan_done  = (scan_q == fill_q);
  assign table_full = (fill_q == CNT_W'(AREA_ENTRIES));
  assign base_match = (rd_q.base == cmd_q.address);

  // Address in [base, base + length) with the end taken without wrap.
  assign in_area = (cmd_q.address >= rd_q.base) &&
                   ((cmd_q.address - rd_q.base) < rd_q.length);

  // The scan ends early on a matching base or on a hit in a freed area.
  assign scan_stop = ((cmd_q.cmd == CMD_ALLOC || cmd_q.cmd == CMD_FREE) && base_match) ||
                     (cmd_q.cmd == CMD_CHECK && rd_q.freed && in_area);

  assign cmd_ready_o = (state_q == S_IDLE);
  assign cmd_take    = cmd_valid_i && cmd_ready_o;
  assign rsp_load    = (state_q == S_FINISH) && (!rsp_valid_q || rsp_o.ready);

  // Table write and read controls.
  always_comb begin
    mem_we          = 1'b0;
    mem_waddr       = scan_idx;
    mem_wdata.freed = 1'b0;
    mem_wdata.length = pending_q;
    mem_wdata.base  = cmd_q.address;
    unique case (state_q)
      S_READ: begin
        // New base: append it after the last filled entry.
        if (scan_done && cmd_q.cmd == CMD_ALLOC && !table_full) begin
          mem_we    = 1'b1;
          mem_waddr = fill_q[IDX_W-1:0];
        end
      end
      S_EVAL: begin
        if (base_match && cmd_q.cmd == CMD_ALLOC) begin
          mem_we = 1'b1;
        end else if (base_match && cmd_q.cmd == CMD_FREE) begin
          mem_we           = 1'b1;
          mem_wdata.freed  = 1'b1;
          mem_wdata.length = rd_q.length;
        end
      end
      S_IDLE, S_FINISH: begin
        mem_we = 1'b0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign mem_re = (state_q == S_READ) && !scan_done;

  // Area table memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      area_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= area_mem[scan_idx];
    end
  end

  // Command sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      scan_q      <= '0;
      pending_q   <= '0;
      hit_q       <= 1'b0;
      full_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      // A new response may be loaded in the cycle the old one is taken.
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.valid && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            scan_q <= '0;
            hit_q  <= 1'b0;
            full_q <= 1'b0;
            case (cmd_i.cmd) inside
              CMD_SET_SIZE: begin
                pending_q <= cmd_i.operand;
                state_q   <= S_FINISH;
              end
              CMD_ALLOC, CMD_FREE, CMD_CHECK: begin
                state_q <= S_READ;
              end
              default: begin
                state_q <= S_FINISH;
              end
            endcase
          end
        end
        S_READ: begin
          if (scan_done) begin
            if (cmd_q.cmd == CMD_ALLOC) begin
              if (table_full) begin
                full_q <= 1'b1;
              end else begin
                fill_q <= fill_q + CNT_W'(1);
              end
            end
            state_q <= S_FINISH;
          end else begin
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (scan_stop) begin
            hit_q   <= (cmd_q.cmd == CMD_CHECK);
            state_q <= S_FINISH;
          end else begin
            scan_q  <= scan_q + CNT_W'(1);
            state_q <= S_READ;
          end
        end
        S_FINISH: begin
          if (rsp_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Command and response payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_take) begin
      cmd_q <= cmd_i;
    end
    if (rsp_load) begin
      rsp_q.uaf_detected      <= hit_q;
      rsp_q.fault_is_write    <= hit_q & cmd_q.is_write;
      rsp_q.fault_address     <= hit_q ? cmd_q.address : '0;
      rsp_q.fault_instruction <= hit_q ? cmd_q.operand : '0;
      rsp_q.area_table_full   <= full_q;
    end
  end

  assign rsp_o.valid             = rsp_valid_q;
  assign rsp_o.uaf_detected      = rsp_q.uaf_detected;
  assign rsp_o.fault_is_write    = rsp_q.fault_is_write;
  assign rsp_o.fault_address     = rsp_q.fault_address;
  assign rsp_o.fault_instruction = rsp_q.fault_instruction;
  assign rsp_o.area_table_full   = rsp_q.area_table_full;

endmodule

// File: sv/heap_use_after_free_checker_unit.sv
// Flow: an accepted request waits in the front-end queue until the back end takes it; a
// size record or ignored request goes straight to S_FINISH, while a return, free or
// access scans entries in S_READ and S_EVAL until a match or the last filled entry.
// Throughput: one request at a time in the back end, set by the single table port read
// once per entry; a stalled response holds the next one in the back end.
// Reset empties the table and clears the pending size.
// ----------------------------------------------------------------------------
// Heap use-after-free checker
// Tracks heap areas from allocation and free events and flags memory
// accesses that land inside a freed area.
// ----------------------------------------------------------------------------
module heap_use_after_free_checker_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  huaf_req_if.sink   req_i,
  huaf_rsp_if.source rsp_o
);
  import huaf_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // Request classification and queue.
  huaf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // Table scan and response register.
  huaf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .rsp_o       (rsp_o)
  );

  // The back end is not ready again in the cycle after taking a command.
  a_back_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("back end took two commands in consecutive cycles");

  // A fault report and a full table never come from the same request.
  a_fault_xor_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !(rsp_o.uaf_detected && rsp_o.area_table_full))
    else $error("fault reported on an allocation request");

  // Fault details are zero unless a fault is flagged.
  a_fault_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.uaf_detected |->
      !rsp_o.fault_is_write && rsp_o.fault_address == '0 &&
      rsp_o.fault_instruction == '0)
    else $error("fault details set without a fault");

endmodule

// File: sim/heap_event_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap use-after-free checker: channel monitor and response checker
// Watches the request and response channels, keeps its own copy of the area
// table and compares every response field by field with the prediction.
// ----------------------------------------------------------------------------
module heap_event_monitor (
  input  logic clk_i,
  input  logic rst_ni,
  huaf_req_if  req_mon,
  huaf_rsp_if  rsp_mon,
  output int   fail_count_o,
  output int   outstanding_o,
  output int   uaf_reports_o,
  output int   full_reports_o
);
  import huaf_pkg::*;

  // One request as seen on the channel.
  typedef struct packed {
    logic [OPC_W-1:0]  opcode;
    logic [WORD_W-1:0] address;
    logic [WORD_W-1:0] alloc_size;
    logic              is_write;
    logic [OPN_W-1:0]  operand_count;
    logic [WORD_W-1:0] instr_address;
  } heap_event_t;

  // Shadow copy of the area table and the pending allocation size.
  logic [WORD_W-1:0] shadow_base  [AREA_ENTRIES];
  logic [WORD_W-1:0] shadow_len   [AREA_ENTRIES];
  bit                shadow_freed [AREA_ENTRIES];
  bit                shadow_live  [AREA_ENTRIES];
  logic [WORD_W-1:0] shadow_pending;

  // Responses still owed by the block, oldest first.
  result_t awaited_results [$];

  // Applies one request to the shadow table and returns the response it owes.
  function automatic result_t apply_heap_event(heap_event_t ev);
    result_t     res;
    int          i;
    int          slot;
    bit          found;
    logic [64:0] area_end;
    res   = '0;
    found = 1'b0;
    slot  = -1;
    case (opcode_e'(ev.opcode))
      OP_ALLOC_SIZE: begin
        shadow_pending = ev.alloc_size;
      end
      OP_ALLOC_RET: begin
        // A zero return means the allocation failed and is not tracked.
        if (ev.address != '0) begin
          for (i = 0; i < AREA_ENTRIES; i++) begin
            if (!found && shadow_live[i] && shadow_base[i] == ev.address) begin
              shadow_freed[i] = 1'b0;
              shadow_len[i]   = shadow_pending;
              found           = 1'b1;
            end
          end
          if (!found) begin
            for (i = 0; i < AREA_ENTRIES; i++) begin
              if (slot < 0 && !shadow_live[i]) slot = i;
            end
            if (slot < 0) begin
              res.area_table_full = 1'b1;
            end else begin
              shadow_live[slot]  = 1'b1;
              shadow_freed[slot] = 1'b0;
              shadow_base[slot]  = ev.address;
              shadow_len[slot]   = shadow_pending;
            end
          end
        end
      end
      OP_FREE: begin
        for (i = 0; i < AREA_ENTRIES; i++) begin
          if (!found && shadow_live[i] && shadow_base[i] == ev.address) begin
            shadow_freed[i] = 1'b1;
            found           = 1'b1;
          end
        end
      end
      OP_ACCESS: begin
        // The area end is taken one bit wider so that it cannot wrap.
        if (ev.operand_count == CHECKED_OPERANDS) begin
          for (i = 0; i < AREA_ENTRIES; i++) begin
            area_end = {1'b0, shadow_base[i]} + {1'b0, shadow_len[i]};
            if (shadow_live[i] && shadow_freed[i] && ev.address >= shadow_base[i] &&
                {1'b0, ev.address} < area_end) found = 1'b1;
          end
          if (found) begin
            res.uaf_detected      = 1'b1;
            res.fault_is_write    = ev.is_write;
            res.fault_address     = ev.address;
            res.fault_instruction = ev.instr_address;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Reports one field that differs from its prediction.
  function automatic void check_field(string field, logic [WORD_W-1:0] want,
                                      logic [WORD_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, field, want, got);
      fail_count_o++;
    end
  endfunction

  // Response checking on the response channel, prediction on the request one.
  always @(posedge clk_i or negedge rst_ni) begin
    heap_event_t ev;
    result_t     want;
    result_t     got;
    int          i;
    if (!rst_ni) begin
      shadow_pending = '0;
      for (i = 0; i < AREA_ENTRIES; i++) begin
        shadow_base[i]  = '0;
        shadow_len[i]   = '0;
        shadow_freed[i] = 1'b0;
        shadow_live[i]  = 1'b0;
      end
      awaited_results.delete();
      fail_count_o   = 0;
      outstanding_o  = 0;
      uaf_reports_o  = 0;
      full_reports_o = 0;
    end else begin
      if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
        got.uaf_detected      = rsp_mon.uaf_detected;
        got.fault_is_write    = rsp_mon.fault_is_write;
        got.fault_address     = rsp_mon.fault_address;
        got.fault_instruction = rsp_mon.fault_instruction;
        got.area_table_full   = rsp_mon.area_table_full;
        if (awaited_results.size() == 0) begin
          $display("%0t ns: response with none outstanding, expected nothing, got %h",
                   $time, got);
          fail_count_o++;
        end else begin
          want = awaited_results.pop_front();
          check_field("uaf_detected", 64'(want.uaf_detected), 64'(got.uaf_detected));
          check_field("fault_is_write", 64'(want.fault_is_write), 64'(got.fault_is_write));
          check_field("fault_address", want.fault_address, got.fault_address);
          check_field("fault_instruction", want.fault_instruction, got.fault_instruction);
          check_field("area_table_full", 64'(want.area_table_full),
                      64'(got.area_table_full));
          if (want.uaf_detected) uaf_reports_o++;
          if (want.area_table_full) full_reports_o++;
        end
      end
      if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
        ev.opcode        = req_mon.opcode;
        ev.address       = req_mon.address;
        ev.alloc_size    = req_mon.alloc_size;
        ev.is_write      = req_mon.access_is_write;
        ev.operand_count = req_mon.operand_count;
        ev.instr_address = req_mon.instr_address;
        awaited_results.insert(awaited_results.size(), apply_heap_event(ev));
      end
      outstanding_o = awaited_results.size();
    end
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap use-after-free checker: testbench top
// Drives directed and random heap events into the block with random gaps on
// both channels; the monitor beside the block checks every response.
// ----------------------------------------------------------------------------
module testbench;
  import huaf_pkg::*;

  localparam logic [WORD_W-1:0] ALL_ONES    = '1;
  localparam logic [WORD_W-1:0] LOW_BASE    = 64'h0000_0000_0000_1000;
  localparam logic [WORD_W-1:0] SECOND_BASE = 64'h0000_0000_0000_2000;
  localparam logic [WORD_W-1:0] THIRD_BASE  = 64'h0000_0000_0000_2100;
  localparam logic [WORD_W-1:0] TOP_BASE    = 64'hFFFF_FFFF_FFFF_FF00;
  localparam int unsigned       RANDOM_REQS = 750;
  localparam int unsigned       DRAIN_CYCLES = 2 * AREA_ENTRIES + 20;

  logic clk_i;
  logic rst_ni;

  huaf_req_if req_bus ();
  huaf_rsp_if rsp_bus ();

  int fail_count;
  int outstanding;
  int uaf_reports;
  int full_reports;

  // Set during stretches in which neither side inserts gaps.
  bit calm;

  // Areas handed out so far, used only to aim frees and accesses.
  logic [WORD_W-1:0] known_base [$];
  logic [WORD_W-1:0] known_len  [$];
  logic [WORD_W-1:0] next_size;
  int                sent;

  heap_use_after_free_checker_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  heap_event_monitor i_monitor (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_mon        (req_bus),
    .rsp_mon        (rsp_bus),
    .fail_count_o   (fail_count),
    .outstanding_o  (outstanding),
    .uaf_reports_o  (uaf_reports),
    .full_reports_o (full_reports)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [WORD_W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Gap length in cycles: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Bases cluster in one region so that areas overlap, with some at the top.
  function automatic logic [WORD_W-1:0] pick_base();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 64'h0000_7F00_0000_0000 + 64'($urandom_range(0, 65535)) * 16;
    if (r < 85) return 64'hFFFF_FFFF_FFFF_F000 + 64'($urandom_range(1, 255)) * 16;
    if (r < 90) return 64'($urandom_range(1, 64));
    return rand64();
  endfunction

  function automatic logic [WORD_W-1:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 80) return 64'($urandom_range(1, 256));
    if (r < 92) return 64'($urandom_range(257, 1 << 20));
    if (r < 96) return ALL_ONES;
    return rand64();
  endfunction

  // Access addresses sit on or next to the edges of a known area, or inside, or are random.
  function automatic logic [WORD_W-1:0] aim_address();
    int idx;
    logic [WORD_W-1:0] base;
    logic [WORD_W-1:0] len;
    if (known_base.size() == 0 || $urandom_range(0, 4) == 0) return rand64();
    idx  = $urandom_range(0, known_base.size() - 1);
    base = known_base[idx];
    len  = known_len[idx];
    case ($urandom_range(0, 5))
      0: return base;
      1: return base + len - 1;
      2: return base + len;
      3: return base - 1;
      default: return (len == '0) ? base : base + (rand64() % len);
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] pick_known_base();
    return known_base[$urandom_range(0, known_base.size() - 1)];
  endfunction

  // Sends one request after an optional gap and waits until it is accepted.
  task automatic send_req(opcode_e op, logic [WORD_W-1:0] addr, logic [WORD_W-1:0] size,
                          logic wr, logic [OPN_W-1:0] opn, logic [WORD_W-1:0] instr);
    int gap;
    int idx;
    gap = pick_gap();
    idx = -1;
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid           <= 1'b1;
    req_bus.opcode          <= op;
    req_bus.address         <= addr;
    req_bus.alloc_size      <= size;
    req_bus.access_is_write <= wr;
    req_bus.operand_count   <= opn;
    req_bus.instr_address   <= instr;
    do @(posedge clk_i); while (req_bus.ready !== 1'b1);
    sent++;
    // Keep the list of handed-out areas roughly in step with the table.
    if (op == OP_ALLOC_SIZE) begin
      next_size = size;
    end else if (op == OP_ALLOC_RET && addr != '0) begin
      foreach (known_base[k]) if (known_base[k] == addr) idx = k;
      if (idx >= 0) begin
        known_len[idx] = next_size;
      end else if (known_base.size() < AREA_ENTRIES) begin
        known_base.insert(known_base.size(), addr);
        known_len.insert(known_len.size(), next_size);
      end
    end
  endtask

  // Response side: ready drops for random stretches.
  initial begin
    int gap;
    rsp_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  end

  // Stimulus and verdict.
  initial begin
    int r;
    int iter;
    int rand_start;
    logic [WORD_W-1:0] base;
    sent      = 0;
    iter      = 0;
    calm      = 1'b0;
    next_size = '0;
    rst_ni                  <= 1'b0;
    req_bus.valid           <= 1'b0;
    req_bus.opcode          <= OP_ALLOC_SIZE;
    req_bus.address         <= '0;
    req_bus.alloc_size      <= '0;
    req_bus.access_is_write <= 1'b0;
    req_bus.operand_count   <= '0;
    req_bus.instr_address   <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty table, zero return, edges of a freed area.
    send_req(OP_ACCESS, LOW_BASE, '0, 1'b1, CHECKED_OPERANDS, ALL_ONES);
    send_req(OP_ALLOC_RET, '0, ALL_ONES, 1'b0, '0, '0);
    send_req(OP_ALLOC_SIZE, ALL_ONES, 64'd16, 1'b1, 4'hF, ALL_ONES);
    send_req(OP_ALLOC_RET, LOW_BASE, '0, 1'b0, '0, '0);
    send_req(OP_ACCESS, LOW_BASE, '0, 1'b1, CHECKED_OPERANDS, ALL_ONES);
    send_req(OP_FREE, LOW_BASE, '0, 1'b0, '0, '0);
    send_req(OP_ACCESS, LOW_BASE, '0, 1'b1, CHECKED_OPERANDS, ALL_ONES);
    send_req(OP_ACCESS, LOW_BASE + 15, '0, 1'b0, CHECKED_OPERANDS, '0);
    send_req(OP_ACCESS, LOW_BASE + 16, '0, 1'b1, CHECKED_OPERANDS, ALL_ONES);
    send_req(OP_ACCESS, LOW_BASE - 1, '0, 1'b1, CHECKED_OPERANDS, ALL_ONES);
    send_req(OP_ACCESS, LOW_BASE, '0, 1'b1, 4'd3, ALL_ONES);
    send_req(OP_ACCESS, LOW_BASE, '0, 1'b1, 4'hF, ALL_ONES);
    send_req(OP_FREE, 64'h3000, '0, 1'b0, '0, '0);
    // An area reaching the top of the address space must not wrap to zero.
    send_req(OP_ALLOC_SIZE, '0, ALL_ONES, 1'b0, '0, '0);
    send_req(OP_ALLOC_RET, TOP_BASE, '0, 1'b0, '0, '0);
    send_req(OP_FREE, TOP_BASE, '0, 1'b0, '0, '0);
    send_req(OP_ACCESS, ALL_ONES, ALL_ONES, 1'b0, CHECKED_OPERANDS, 64'h1234);
    send_req(OP_ACCESS, '0, '0, 1'b1, CHECKED_OPERANDS, ALL_ONES);
    // Re-allocation of a freed base with a zero length never hits.
    send_req(OP_ALLOC_SIZE, '0, '0, 1'b0, '0, '0);
    send_req(OP_ALLOC_RET, LOW_BASE, '0, 1'b0, '0, '0);
    send_req(OP_FREE, LOW_BASE, '0, 1'b0, '0, '0);
    send_req(OP_ACCESS, LOW_BASE, '0, 1'b1, CHECKED_OPERANDS, ALL_ONES);
    // The pending size is kept across two returns.
    send_req(OP_ALLOC_SIZE, '0, 64'd32, 1'b0, '0, '0);
    send_req(OP_ALLOC_RET, SECOND_BASE, '0, 1'b0, '0, '0);
    send_req(OP_ALLOC_RET, THIRD_BASE, '0, 1'b0, '0, '0);
    send_req(OP_FREE, THIRD_BASE, '0, 1'b0, '0, '0);
    send_req(OP_ACCESS, THIRD_BASE + 31, '0, 1'b1, CHECKED_OPERANDS, 64'hABCD);

    // Random part: allocation pairs, frees, aimed accesses and some noise.
    rand_start = sent;
    while (sent - rand_start < RANDOM_REQS) begin
      iter++;
      if (iter % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 35) begin
        send_req(OP_ALLOC_SIZE, rand64(), pick_size(), 1'($urandom_range(0, 1)),
                 4'($urandom_range(0, 15)), rand64());
        base = (known_base.size() != 0 && $urandom_range(0, 3) == 0) ?
               pick_known_base() : pick_base();
        send_req(OP_ALLOC_RET, base, rand64(), 1'($urandom_range(0, 1)),
                 4'($urandom_range(0, 15)), rand64());
      end else if (r < 55) begin
        base = (known_base.size() != 0 && $urandom_range(0, 99) < 85) ?
               pick_known_base() : pick_base();
        send_req(OP_FREE, base, rand64(), 1'($urandom_range(0, 1)),
                 4'($urandom_range(0, 15)), rand64());
      end else if (r < 92) begin
        send_req(OP_ACCESS, aim_address(), rand64(), 1'($urandom_range(0, 1)),
                 ($urandom_range(0, 99) < 85) ? CHECKED_OPERANDS : 4'($urandom_range(0, 15)),
                 rand64());
      end else begin
        send_req(opcode_e'($urandom_range(0, 3)), rand64(), rand64(),
                 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), rand64());
      end
    end
    req_bus.valid <= 1'b0;
    @(posedge clk_i);

    // Drain the outstanding responses, then allow for a stray one.
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d requests: %0d use-after-free reports, %0d table-full responses.",
             sent, uaf_reports, full_reports);
    $display("Areas aimed at by stimulus: %0d, mismatches: %0d.", known_base.size(), fail_count);
    if (fail_count == 0) begin
      $display("heap_use_after_free_checker_unit regression: pass");
    end else begin
      $display("heap_use_after_free_checker_unit regression: fail");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #15_000_000;
    $display("Timeout with %0d responses outstanding.", outstanding);
    $display("heap_use_after_free_checker_unit regression: fail");
    $finish;
  end

endmodule
